@@ sv/rti_pkg.sv @@
// shared types and constants of the ray/triangle intersection engine
// no dependencies; imported by rti_store and ray_triangle_intersect
`default_nettype none

package rti_pkg;

  // field widths
  localparam int IDX_W     = 10;
  localparam int COORD_W   = 32;
  localparam int TMAX_W    = 31;
  localparam int BARY_W    = 17;
  localparam int BARY_FRAC = 16;
  localparam int VTX_W     = 3 * COORD_W;
  localparam int TRI_W     = 3 * IDX_W;

  // datapath widths: edge, cross product, dot product, divider
  localparam int EW = COORD_W + 1;
  localparam int XW = 2 * EW + 1;
  localparam int DW = XW + EW + 2;
  localparam int QB = TMAX_W;
  localparam int NW = DW + 32;

  // stream widths
  localparam int S_DATA_W = 264;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 72;
  localparam int M_USER_W = 1;

  // input item layout in s_axis_tdata
  localparam int OFF_IDX  = 0;
  localparam int OFF_PT   = 10;
  localparam int OFF_DIR  = 106;
  localparam int OFF_TMAX = 202;
  localparam int OFF_TRI  = 233;

  // commands carried in s_axis_tuser
  localparam logic [1:0] CMD_VERTEX   = 2'd0;
  localparam logic [1:0] CMD_TRIANGLE = 2'd1;
  localparam logic [1:0] CMD_TEST     = 2'd2;
  // spare code, changes nothing and answers like a write
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  // per-item control that travels beside the datapath
  typedef struct packed {
    logic              valid;
    logic              test;
    logic              miss;
    logic [TMAX_W-1:0] tmax;
  } side_t;

  // memory port enables
  typedef struct packed {
    logic tri_we;
    logic tri_re;
    logic vtx_we;
    logic vtx_re;
  } mem_ctl_t;

endpackage

`default_nettype wire

@@ sv/rti_mul.sv @@
// two-stage signed multiplier, the wide operand split into two partial products
// uses no package items
`default_nettype none

module rti_mul #(
  parameter int AW = 67,
  parameter int BW = 33
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int LW = AW / 2;
  localparam int HW = AW - LW;
  localparam int PW = AW + BW;

  logic signed [LW:0]      a_lo;
  logic signed [HW-1:0]    a_hi;
  logic signed [LW+BW:0]   pp_lo;
  logic signed [HW+BW-1:0] pp_hi;

  // low half taken as unsigned, high half keeps the sign
  assign a_lo = $signed({1'b0, a[LW-1:0]});
  assign a_hi = a[AW-1:LW];

  // partial products, then recombine
  always_ff @(posedge clk) begin
    if (en) begin
      pp_lo <= a_lo * b;
      pp_hi <= a_hi * b;
      p     <= (PW'(pp_hi) <<< LW) + PW'(pp_lo);
    end
  end

endmodule

`default_nettype wire

@@ sv/rti_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// caller guarantees the quotient fits in QB bits and den << (QB-1) fits in NW
`default_nettype none

module rti_div #(
  parameter int NW = 134,
  parameter int QB = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  output logic [QB-1:0] quo,
  output logic          rem_nz
);

  logic [NW-1:0] r [QB];
  logic [NW-1:0] d [QB];
  logic [QB-1:0] q [QB];

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [NW-1:0] rs;
    logic [NW-1:0] ds;
    logic [QB-1:0] qs;
    logic [NW-1:0] trial;
    logic          fits;

    if (s == 0) begin : g_first
      assign rs = num;
      assign ds = den;
      assign qs = '0;
    end else begin : g_next
      assign rs = r[s-1];
      assign ds = d[s-1];
      assign qs = q[s-1];
    end

    // try to take off the divisor at this bit weight
    assign trial = ds << (QB - 1 - s);
    assign fits  = rs >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        r[s] <= fits ? rs - trial : rs;
        d[s] <= ds;
        q[s] <= qs | (QB'(fits) << (QB - 1 - s));
      end
    end
  end

  assign quo    = q[QB-1];
  assign rem_nz = |r[QB-1];

endmodule

`default_nettype wire

@@ sv/rti_store.sv @@
// triangle table and vertex table, synchronous memories with registered read
// depends on rti_pkg; the vertex table is kept in three copies for three reads
`default_nettype none

module rti_store #(
  parameter int MAX_VERTICES  = 1024,
  parameter int MAX_TRIANGLES = 1024
) (
  input  logic                         clk,
  input  rti_pkg::mem_ctl_t            ctl,
  input  logic [rti_pkg::IDX_W-1:0]    tri_idx,
  input  logic [rti_pkg::TRI_W-1:0]    tri_wdata,
  output logic [rti_pkg::TRI_W-1:0]    tri_rdata,
  input  logic [rti_pkg::IDX_W-1:0]    vtx_idx,
  input  logic [rti_pkg::VTX_W-1:0]    vtx_wdata,
  input  logic [rti_pkg::TRI_W-1:0]    vtx_raddr,
  output logic [rti_pkg::VTX_W-1:0]    vtx_a,
  output logic [rti_pkg::VTX_W-1:0]    vtx_b,
  output logic [rti_pkg::VTX_W-1:0]    vtx_c
);

  import rti_pkg::*;

  localparam int TA = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int VA = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  logic [TRI_W-1:0] tri_mem [MAX_TRIANGLES];
  logic [VTX_W-1:0] vmem_a  [MAX_VERTICES];
  logic [VTX_W-1:0] vmem_b  [MAX_VERTICES];
  logic [VTX_W-1:0] vmem_c  [MAX_VERTICES];

  logic [TA-1:0] tri_addr;
  logic [VA-1:0] vtx_waddr;
  logic [VA-1:0] rd_a;
  logic [VA-1:0] rd_b;
  logic [VA-1:0] rd_c;

  assign tri_addr  = TA'(tri_idx);
  assign vtx_waddr = VA'(vtx_idx);
  assign rd_a      = VA'(vtx_raddr[IDX_W-1:0]);
  assign rd_b      = VA'(vtx_raddr[2*IDX_W-1:IDX_W]);
  assign rd_c      = VA'(vtx_raddr[3*IDX_W-1:2*IDX_W]);

  // triangle table
  always_ff @(posedge clk) begin
    if (ctl.tri_we) begin
      tri_mem[tri_addr] <= tri_wdata;
    end
    if (ctl.tri_re) begin
      tri_rdata <= tri_mem[tri_addr];
    end
  end

  // vertex table, one copy per corner read
  always_ff @(posedge clk) begin
    if (ctl.vtx_we) begin
      vmem_a[vtx_waddr] <= vtx_wdata;
      vmem_b[vtx_waddr] <= vtx_wdata;
      vmem_c[vtx_waddr] <= vtx_wdata;
    end
    if (ctl.vtx_re) begin
      vtx_a <= vmem_a[rd_a];
      vtx_b <= vmem_b[rd_b];
      vtx_c <= vmem_c[rd_c];
    end
  end

endmodule

`default_nettype wire

@@ sv/ray_triangle_intersect.sv @@
// Moller-Trumbore ray/triangle test engine in fixed point, top level
// depends on rti_pkg, rti_store, rti_mul and rti_div
//
// Takes one item per cycle unless the pipeline holds, and returns one result item per
// input item, in order. The result item passes through 11 datapath stages (the first
// loaded at acceptance), 31 divider stages and the output register. Items are vertex
// writes, triangle writes and ray tests; writes return hit 0 and echo ray_t_max.
// The triangle table is read and written at acceptance and the vertex table as the
// item leaves stage a, so a test always sees every write accepted before it. The
// whole pipeline holds while the output item is not taken. Tables are undefined
// until written.
`default_nettype none

module ray_triangle_intersect #(
  parameter int MAX_VERTICES  = 1024,
  parameter int MAX_TRIANGLES = 1024,
  parameter int FRAC_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // entry_index, point_x, point_y, point_z, dir_x, dir_y, dir_z, ray_t_max,
  // corner_a, corner_b, corner_c, one pad bit
  input  logic [rti_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic [rti_pkg::S_USER_W-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // bary_u, bary_v, new_t_max, seven pad bits
  output logic [rti_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // hit
  output logic [rti_pkg::M_USER_W-1:0]  m_axis_tuser
);

  import rti_pkg::*;

  localparam int K_IDX = 10;
  localparam int NSB   = K_IDX + 1 + QB;
  localparam int SW    = DW + 1;
  localparam int PRW   = XW + EW;
  localparam logic [NW-1:0] EPS =
      ((NW'(1) << (3 * FRAC_BITS)) + NW'(999999)) / NW'(1000000);

  logic                 adv;
  logic                 acc;
  logic [IDX_W-1:0]     s_idx;
  logic                 s_idx_tri_ok;
  logic                 s_idx_vtx_ok;
  mem_ctl_t             mem_ctl;
  side_t                sb    [NSB];
  side_t                sb_in [NSB];

  logic                 a_vwe;
  logic [IDX_W-1:0]     a_idx;
  logic [VTX_W-1:0]     a_pt;
  logic [VTX_W-1:0]     a_dir;
  logic [TRI_W-1:0]     tri_rdata;
  logic                 corner_oob;

  logic [VTX_W-1:0]     b_pt;
  logic [VTX_W-1:0]     b_dir;
  logic [VTX_W-1:0]     vtx_a;
  logic [VTX_W-1:0]     vtx_b;
  logic [VTX_W-1:0]     vtx_c;
  logic signed [COORD_W-1:0] va [3];
  logic signed [COORD_W-1:0] vb [3];
  logic signed [COORD_W-1:0] vc [3];
  logic signed [COORD_W-1:0] vo [3];
  logic signed [COORD_W-1:0] vd [3];

  logic signed [EW-1:0] c_e1 [3];
  logic signed [EW-1:0] c_e2 [3];
  logic signed [EW-1:0] c_t  [3];
  logic signed [EW-1:0] c_d  [3];
  logic signed [EW-1:0] dl_e1 [3][3];
  logic signed [EW-1:0] dl_e2 [3][3];
  logic signed [EW-1:0] dl_t  [3][3];
  logic signed [EW-1:0] dl_d  [3][3];

  logic signed [2*EW-1:0] pm0 [3];
  logic signed [2*EW-1:0] pm1 [3];
  logic signed [2*EW-1:0] qm0 [3];
  logic signed [2*EW-1:0] qm1 [3];
  logic signed [XW-1:0]   f_p [3];
  logic signed [XW-1:0]   f_q [3];

  logic signed [PRW-1:0]  md [3];
  logic signed [PRW-1:0]  mu [3];
  logic signed [PRW-1:0]  mv [3];
  logic signed [PRW-1:0]  mn [3];

  logic signed [DW-1:0] i_det;
  logic signed [DW-1:0] i_nu;
  logic signed [DW-1:0] i_nv;
  logic signed [DW-1:0] i_nd;
  logic signed [DW-1:0] j_det;
  logic signed [DW-1:0] j_nu;
  logic signed [DW-1:0] j_nv;
  logic signed [DW-1:0] j_nd;
  logic signed [SW-1:0] uv_sum;
  logic                 arith_miss;

  logic [NW-1:0] k_det;
  logic [NW-1:0] k_nu;
  logic [NW-1:0] k_nv;
  logic [NW-1:0] k_nd;
  logic [QB-1:0] quo_u;
  logic [QB-1:0] quo_v;
  logic [QB-1:0] quo_d;
  logic          rem_nz_d;
  logic          late_miss;
  logic          z_hit;

  // handshake: every stage moves together when the output can take an item
  assign adv           = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid & adv;

  assign s_idx        = s_axis_tdata[OFF_IDX +: IDX_W];
  assign s_idx_tri_ok = 32'(s_idx) < 32'(MAX_TRIANGLES);
  assign s_idx_vtx_ok = 32'(s_idx) < 32'(MAX_VERTICES);

  // memory enables
  always_comb begin
    mem_ctl.tri_we = acc & (s_axis_tuser == CMD_TRIANGLE) & s_idx_tri_ok;
    mem_ctl.tri_re = adv;
    mem_ctl.vtx_we = adv & sb[0].valid & a_vwe;
    mem_ctl.vtx_re = adv;
  end

  rti_store #(
    .MAX_VERTICES  (MAX_VERTICES),
    .MAX_TRIANGLES (MAX_TRIANGLES)
  ) u_store (
    .clk       (clk),
    .ctl       (mem_ctl),
    .tri_idx   (s_idx),
    .tri_wdata (s_axis_tdata[OFF_TRI +: TRI_W]),
    .tri_rdata (tri_rdata),
    .vtx_idx   (a_idx),
    .vtx_wdata (a_pt),
    .vtx_raddr (tri_rdata),
    .vtx_a     (vtx_a),
    .vtx_b     (vtx_b),
    .vtx_c     (vtx_c)
  );

  assign corner_oob = (32'(tri_rdata[IDX_W-1:0]) >= 32'(MAX_VERTICES)) ||
                      (32'(tri_rdata[2*IDX_W-1:IDX_W]) >= 32'(MAX_VERTICES)) ||
                      (32'(tri_rdata[3*IDX_W-1:2*IDX_W]) >= 32'(MAX_VERTICES));

  // side channel: entry, corner range at stage b, arithmetic rejects at stage k
  always_comb begin
    sb_in[0].valid = s_axis_tvalid;
    sb_in[0].test  = s_axis_tuser == CMD_TEST;
    sb_in[0].miss  = ~s_idx_tri_ok;
    sb_in[0].tmax  = s_axis_tdata[OFF_TMAX +: TMAX_W];
    for (int i = 1; i < NSB; i++) begin
      sb_in[i] = sb[i-1];
    end
    sb_in[1].miss     = sb[0].miss | corner_oob;
    sb_in[K_IDX].miss = sb[K_IDX-1].miss | arith_miss;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSB; i++) begin
        sb[i] <= '0;
      end
      a_vwe         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      sb            <= sb_in;
      a_vwe         <= (s_axis_tuser == CMD_VERTEX) & s_idx_vtx_ok;
      m_axis_tvalid <= sb[NSB-1].valid;
    end
  end

  // coordinate views of stage b
  for (genvar k = 0; k < 3; k++) begin : g_coord
    assign va[k] = vtx_a[COORD_W*k +: COORD_W];
    assign vb[k] = vtx_b[COORD_W*k +: COORD_W];
    assign vc[k] = vtx_c[COORD_W*k +: COORD_W];
    assign vo[k] = b_pt[COORD_W*k +: COORD_W];
    assign vd[k] = b_dir[COORD_W*k +: COORD_W];
  end

  // stages a to c: capture, vertex fetch, edges
  always_ff @(posedge clk) begin
    if (adv) begin
      a_idx <= s_idx;
      a_pt  <= s_axis_tdata[OFF_PT +: VTX_W];
      a_dir <= s_axis_tdata[OFF_DIR +: VTX_W];
      b_pt  <= a_pt;
      b_dir <= a_dir;
      for (int k = 0; k < 3; k++) begin
        c_e1[k] <= EW'(vb[k]) - EW'(va[k]);
        c_e2[k] <= EW'(vc[k]) - EW'(va[k]);
        c_t[k]  <= EW'(vo[k]) - EW'(va[k]);
        c_d[k]  <= EW'(vd[k]);
      end
      dl_e1[0] <= c_e1;
      dl_e2[0] <= c_e2;
      dl_t[0]  <= c_t;
      dl_d[0]  <= c_d;
      for (int s = 1; s < 3; s++) begin
        dl_e1[s] <= dl_e1[s-1];
        dl_e2[s] <= dl_e2[s-1];
        dl_t[s]  <= dl_t[s-1];
        dl_d[s]  <= dl_d[s-1];
      end
    end
  end

  // cross products p = d x e2 and q = t x e1, one component per lane
  for (genvar k = 0; k < 3; k++) begin : g_cross
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;

    rti_mul #(.AW(EW), .BW(EW)) u_pm0 (
      .clk (clk), .en (adv), .a (c_d[K1]), .b (c_e2[K2]), .p (pm0[k])
    );
    rti_mul #(.AW(EW), .BW(EW)) u_pm1 (
      .clk (clk), .en (adv), .a (c_d[K2]), .b (c_e2[K1]), .p (pm1[k])
    );
    rti_mul #(.AW(EW), .BW(EW)) u_qm0 (
      .clk (clk), .en (adv), .a (c_t[K1]), .b (c_e1[K2]), .p (qm0[k])
    );
    rti_mul #(.AW(EW), .BW(EW)) u_qm1 (
      .clk (clk), .en (adv), .a (c_t[K2]), .b (c_e1[K1]), .p (qm1[k])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        f_p[k] <= XW'(pm0[k]) - XW'(pm1[k]);
        f_q[k] <= XW'(qm0[k]) - XW'(qm1[k]);
      end
    end

    // dot product terms: det, u, v and distance numerators
    rti_mul #(.AW(XW), .BW(EW)) u_md (
      .clk (clk), .en (adv), .a (f_p[k]), .b (dl_e1[2][k]), .p (md[k])
    );
    rti_mul #(.AW(XW), .BW(EW)) u_mu (
      .clk (clk), .en (adv), .a (f_p[k]), .b (dl_t[2][k]), .p (mu[k])
    );
    rti_mul #(.AW(XW), .BW(EW)) u_mv (
      .clk (clk), .en (adv), .a (f_q[k]), .b (dl_d[2][k]), .p (mv[k])
    );
    rti_mul #(.AW(XW), .BW(EW)) u_mn (
      .clk (clk), .en (adv), .a (f_q[k]), .b (dl_e2[2][k]), .p (mn[k])
    );
  end

  // rejection tests on the sign-normalized values
  assign uv_sum = SW'(j_nu) + SW'(j_nv);

  always_comb begin
    arith_miss = 1'b0;
    if (NW'($unsigned(j_det)) < EPS) begin
      arith_miss = 1'b1;
    end
    if (j_nu[DW-1] || (j_nu > j_det)) begin
      arith_miss = 1'b1;
    end
    if (j_nv[DW-1] || (uv_sum > SW'(j_det))) begin
      arith_miss = 1'b1;
    end
    if (j_nd[DW-1] || (j_nd == '0)) begin
      arith_miss = 1'b1;
    end
    // distance quotient of 2^31 or more is past any ray_t_max
    if ((NW'($unsigned(j_nd)) << FRAC_BITS) >= (NW'($unsigned(j_det)) << QB)) begin
      arith_miss = 1'b1;
    end
  end

  // stages i to k: sums, sign fold, divider operands
  always_ff @(posedge clk) begin
    if (adv) begin
      i_det <= DW'(md[0]) + DW'(md[1]) + DW'(md[2]);
      i_nu  <= DW'(mu[0]) + DW'(mu[1]) + DW'(mu[2]);
      i_nv  <= DW'(mv[0]) + DW'(mv[1]) + DW'(mv[2]);
      i_nd  <= DW'(mn[0]) + DW'(mn[1]) + DW'(mn[2]);
      j_det <= i_det[DW-1] ? -i_det : i_det;
      j_nu  <= i_det[DW-1] ? -i_nu  : i_nu;
      j_nv  <= i_det[DW-1] ? -i_nv  : i_nv;
      j_nd  <= i_det[DW-1] ? -i_nd  : i_nd;
      k_det <= NW'($unsigned(j_det));
      k_nu  <= NW'($unsigned(j_nu)) << BARY_FRAC;
      k_nv  <= NW'($unsigned(j_nv)) << BARY_FRAC;
      k_nd  <= NW'($unsigned(j_nd)) << FRAC_BITS;
    end
  end

  // quotients
  rti_div #(.NW(NW), .QB(QB)) u_div_d (
    .clk (clk), .en (adv), .num (k_nd), .den (k_det), .quo (quo_d), .rem_nz (rem_nz_d)
  );
  rti_div #(.NW(NW), .QB(QB)) u_div_u (
    .clk (clk), .en (adv), .num (k_nu), .den (k_det), .quo (quo_u), .rem_nz ()
  );
  rti_div #(.NW(NW), .QB(QB)) u_div_v (
    .clk (clk), .en (adv), .num (k_nv), .den (k_det), .quo (quo_v), .rem_nz ()
  );

  // distance against the current maximum, exact
  assign late_miss = (quo_d > sb[NSB-1].tmax) ||
                     ((quo_d == sb[NSB-1].tmax) && rem_nz_d);
  assign z_hit     = sb[NSB-1].test & ~sb[NSB-1].miss & ~late_miss;

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tuser[0] <= z_hit;
      m_axis_tdata    <= {7'd0,
                          z_hit ? quo_d : sb[NSB-1].tmax,
                          z_hit ? BARY_W'(quo_v) : BARY_W'(0),
                          z_hit ? BARY_W'(quo_u) : BARY_W'(0)};
    end
  end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for ray_triangle_intersect: directed and random items
// depends on rti_pkg and the ray_triangle_intersect rtl; predicts every result
`default_nettype none

module tb;
  import rti_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [31:0] coord_t;

  typedef struct {
    logic [1:0]        cmd;
    logic [IDX_W-1:0]  idx;
    coord_t            pt [3];
    coord_t            dir [3];
    logic [TMAX_W-1:0] tmax;
    logic [IDX_W-1:0]  corner [3];
  } ray_item_t;

  typedef struct {
    logic              hit;
    logic [BARY_W-1:0] u;
    logic [BARY_W-1:0] v;
    logic [TMAX_W-1:0] t;
  } hit_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [S_USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [M_USER_W-1:0] m_axis_tuser;

  ray_triangle_intersect dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state: table copies and which slots hold data
  coord_t           vtx_copy [1024][3];
  logic [IDX_W-1:0] tri_copy [1024][3];
  bit               vtx_written [1024];
  bit               tri_written [1024];
  int               vtx_list [$];
  int               tri_list [$];
  hit_result_t      pending_hits [$];

  int  mismatches = 0;
  int  cycles = 0;
  int  burst_left = 0;
  int  rx_hold = 0;
  int  hold_req = 0;
  int  hold_seen = 0;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 300;

  // moller-trumbore in exact wide arithmetic; also applies writes
  function automatic hit_result_t predict_hit(ray_item_t it);
    hit_result_t r;
    wide_t a [3], b [3], c [3], e1 [3], e2 [3], p [3], tv [3], q [3], d [3];
    wide_t det, nu, nv, nd;
    logic [127:0] quo, rem, lim;
    r.hit = 1'b0; r.u = '0; r.v = '0; r.t = it.tmax;
    case (it.cmd)
      CMD_VERTEX: begin
        for (int k = 0; k < 3; k++) vtx_copy[it.idx][k] = it.pt[k];
        if (!vtx_written[it.idx]) vtx_list.push_back(it.idx);
        vtx_written[it.idx] = 1'b1;
      end
      CMD_TRIANGLE: begin
        for (int k = 0; k < 3; k++) tri_copy[it.idx][k] = it.corner[k];
        if (!tri_written[it.idx]) tri_list.push_back(it.idx);
        tri_written[it.idx] = 1'b1;
      end
      CMD_TEST: begin
        for (int k = 0; k < 3; k++) begin
          a[k] = vtx_copy[tri_copy[it.idx][0]][k];
          b[k] = vtx_copy[tri_copy[it.idx][1]][k];
          c[k] = vtx_copy[tri_copy[it.idx][2]][k];
          d[k] = it.dir[k];
          e1[k] = b[k] - a[k];
          e2[k] = c[k] - a[k];
          tv[k] = wide_t'(it.pt[k]) - a[k];
        end
        for (int k = 0; k < 3; k++) begin
          p[k] = d[(k+1)%3] * e2[(k+2)%3] - d[(k+2)%3] * e2[(k+1)%3];
          q[k] = tv[(k+1)%3] * e1[(k+2)%3] - tv[(k+2)%3] * e1[(k+1)%3];
        end
        det = p[0]*e1[0] + p[1]*e1[1] + p[2]*e1[2];
        nu  = p[0]*tv[0] + p[1]*tv[1] + p[2]*tv[2];
        nv  = q[0]*d[0]  + q[1]*d[1]  + q[2]*d[2];
        nd  = q[0]*e2[0] + q[1]*e2[1] + q[2]*e2[2];
        if (det < 0) begin
          det = -det; nu = -nu; nv = -nv; nd = -nd;
        end
        lim = 128'd1 << 48;
        if (det * 1000000 < lim) return r;
        if (nu < 0 || nu > det) return r;
        if (nv < 0 || nu + nv > det) return r;
        if (nd <= 0) return r;
        quo = (128'(nd) << 16) / 128'(det);
        rem = (128'(nd) << 16) % 128'(det);
        if (quo > 128'(it.tmax) || (quo == 128'(it.tmax) && rem != 0)) return r;
        r.hit = 1'b1;
        r.t = quo[TMAX_W-1:0];
        quo = (128'(nu) << BARY_FRAC) / 128'(det);
        r.u = quo[BARY_W-1:0];
        quo = (128'(nv) << BARY_FRAC) / 128'(det);
        r.v = quo[BARY_W-1:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  // sender: bursts with random gaps, item held until taken
  task automatic send_item(ray_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tdata = {1'b0, it.corner[2], it.corner[1], it.corner[0], it.tmax,
                    it.dir[2], it.dir[1], it.dir[0], it.pt[2], it.pt[1], it.pt[0],
                    it.idx};
    s_axis_tuser = it.cmd;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_hits.push_back(predict_hit(it));
  endtask

  // input goes idle first so the last item is not offered again
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  function automatic ray_item_t blank_item(logic [1:0] cmd, int idx);
    ray_item_t it;
    it.cmd = cmd; it.idx = IDX_W'(idx); it.tmax = 31'h7fffffff;
    for (int k = 0; k < 3; k++) begin
      it.pt[k] = '0; it.dir[k] = '0; it.corner[k] = '0;
    end
    return it;
  endfunction

  task automatic put_vertex(int idx, coord_t x, coord_t y, coord_t z);
    ray_item_t it;
    it = blank_item(CMD_VERTEX, idx);
    it.pt[0] = x; it.pt[1] = y; it.pt[2] = z;
    send_item(it);
  endtask

  task automatic put_triangle(int idx, int ca, int cb, int cc);
    ray_item_t it;
    it = blank_item(CMD_TRIANGLE, idx);
    it.corner[0] = IDX_W'(ca); it.corner[1] = IDX_W'(cb); it.corner[2] = IDX_W'(cc);
    send_item(it);
  endtask

  task automatic shoot(int tri_id, coord_t ox, coord_t oy, coord_t oz,
                       coord_t dx, coord_t dy, coord_t dz, logic [TMAX_W-1:0] tmax);
    ray_item_t it;
    it = blank_item(CMD_TEST, tri_id);
    it.pt[0] = ox; it.pt[1] = oy; it.pt[2] = oz;
    it.dir[0] = dx; it.dir[1] = dy; it.dir[2] = dz;
    it.tmax = tmax;
    send_item(it);
  endtask

  // hits, misses of every kind, table extremes and the unused command
  task automatic test_directed();
    ray_item_t it;
    localparam coord_t ONE = 32'sd65536;
    put_vertex(0, 0, 0, 0);
    put_vertex(1, 4 * ONE, 0, 0);
    put_vertex(2, 0, 4 * ONE, 0);
    put_triangle(0, 0, 1, 2);
    shoot(0, ONE, ONE, ONE, 0, 0, -ONE, 31'h7fffffff);       // plain hit
    shoot(0, ONE, ONE, ONE, 0, 0, -ONE, 31'd0);              // beyond max
    shoot(0, ONE, ONE, ONE, 0, 0, -ONE, 31'd65536);          // exactly at max
    shoot(0, ONE, ONE, ONE, ONE, 0, 0, 31'h7fffffff);        // parallel ray
    shoot(0, ONE, ONE, ONE, 0, 0, ONE, 31'h7fffffff);        // behind origin
    shoot(0, -ONE, ONE, ONE, 0, 0, -ONE, 31'h7fffffff);      // u below zero
    shoot(0, 3 * ONE, 3 * ONE, ONE, 0, 0, -ONE, 31'h7fffffff); // u plus v above one
    shoot(0, 4 * ONE, 0, ONE, 0, 0, -ONE, 31'h7fffffff);     // on a corner
    // tiny edges give a near-zero determinant
    put_vertex(3, 1, 0, 0);
    put_vertex(4, 0, 1, 0);
    put_triangle(1, 0, 3, 4);
    shoot(1, 0, 0, ONE, 0, 0, -ONE, 31'h7fffffff);
    // degenerate triangle, extreme coordinates, top slots
    put_vertex(1023, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    put_vertex(1022, 32'h80000000, 32'h7fffffff, 32'h80000000);
    put_triangle(1023, 1023, 1023, 1023);
    shoot(1023, 32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000,
          32'hffffffff, 31'h7fffffff);
    put_triangle(1022, 1023, 1022, 0);
    shoot(1022, 0, 0, 0, 32'h80000000, 32'h7fffffff, 32'h00000001, 31'h7fffffff);
    it = blank_item(CMD_UNUSED, 1023);
    it.tmax = 31'h2aaaaaaa;
    send_item(it);
  endtask

  // one ray aimed at a random point of a known triangle
  task automatic aimed_ray();
    int tri_id, wu, wv, k;
    coord_t a [3], b [3], c [3], o [3], d [3];
    logic [TMAX_W-1:0] tmax;
    tri_id = tri_list[$urandom_range(0, tri_list.size() - 1)];
    wu = $urandom_range(0, 256);
    wv = $urandom_range(0, 256 - wu);
    for (k = 0; k < 3; k++) begin
      a[k] = vtx_copy[tri_copy[tri_id][0]][k];
      b[k] = vtx_copy[tri_copy[tri_id][1]][k];
      c[k] = vtx_copy[tri_copy[tri_id][2]][k];
      d[k] = ((b[k] - a[k]) * wu + (c[k] - a[k]) * wv) / 256 + a[k];
      o[k] = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      d[k] = d[k] - o[k];
      if ($urandom_range(0, 3) == 0) d[k] = d[k] + $signed($urandom_range(0, 31)) - 16;
    end
    case ($urandom_range(0, 3))
      0: tmax = TMAX_W'($urandom);
      1: tmax = TMAX_W'($urandom_range(60000, 70000));
      2: tmax = 31'h7fffffff;
      default: tmax = TMAX_W'($urandom_range(0, 1 << 17));
    endcase
    shoot(tri_id, o[0], o[1], o[2], d[0], d[1], d[2], tmax);
  endtask

  task automatic random_item();
    ray_item_t it;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 12 || vtx_list.size() < 3) begin
      it = blank_item(CMD_VERTEX, $urandom_range(0, 1023));
      for (int k = 0; k < 3; k++)
        it.pt[k] = ($urandom_range(0, 9) == 0) ? $urandom
                                               : $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    end else if (sel < 20 || tri_list.size() == 0) begin
      it = blank_item(CMD_TRIANGLE, $urandom_range(0, 1023));
      for (int k = 0; k < 3; k++)
        it.corner[k] = IDX_W'(vtx_list[$urandom_range(0, vtx_list.size() - 1)]);
    end else if (sel < 75) begin
      aimed_ray();
      return;
    end else begin
      it = blank_item((sel < 92) ? CMD_TEST : CMD_UNUSED,
                      tri_list[$urandom_range(0, tri_list.size() - 1)]);
      it.tmax = TMAX_W'($urandom);
    end
    // ignored fields still carry random bits
    for (int k = 0; k < 3; k++) begin
      if (it.cmd != CMD_VERTEX) it.pt[k] = $urandom;
      if (it.cmd != CMD_TRIANGLE) it.corner[k] = IDX_W'($urandom_range(0, 1023));
      if (it.cmd != CMD_TEST) it.dir[k] = $urandom;
      else if (sel >= 75) it.dir[k] = $urandom;
    end
    if (it.cmd != CMD_TEST) it.tmax = TMAX_W'($urandom);
    send_item(it);
  endtask

  task automatic test_random(int n);
    repeat (n) random_item();
  endtask

  // receiver held off long enough for the pipeline to fill and stall
  task automatic test_backpressure();
    hold_req++;
    repeat (80) random_item();
  endtask

  // sender idles until every result is back
  task automatic test_drain();
    test_random(40);
    wait_drained();
    test_random(40);
  endtask

  // receiver stall pattern and long hold-off
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      rx_hold <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if ((cycles / 500) % 3 == 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // result check against the oldest prediction
  always @(posedge clk) begin
    hit_result_t exp_r, got;
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.hit = m_axis_tuser[0];
      got.u = m_axis_tdata[16:0];
      got.v = m_axis_tdata[33:17];
      got.t = m_axis_tdata[64:34];
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item hit=%0d", got.hit);
      end else begin
        exp_r = pending_hits.pop_front();
        if (got.hit !== exp_r.hit || got.u !== exp_r.u || got.v !== exp_r.v
            || got.t !== exp_r.t) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0d u=%0d v=%0d t=%0d, got hit=%0d u=%0d v=%0d t=%0d",
                     exp_r.hit, exp_r.u, exp_r.v, exp_r.t, got.hit, got.u, got.v, got.t);
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(400);
    test_backpressure();
    test_drain();
    test_random(290);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
